/* design/dcns_pkg.sv */
// Shared types, constants and geometry helpers of the directional cone search unit.
package dcns_pkg;

    localparam int MAX_WINDOWS_DEF = 32;
    localparam int SLOT_FIELD_W    = 5;
    localparam int COORD_W         = 16;
    localparam int ORIGIN_W        = 18;
    localparam int CENTER_W        = 19;
    localparam int DELTA_W         = 20;
    localparam int SQ_W            = 37;
    localparam int DIST_W          = 38;
    localparam int IDX_EXT_W       = 9;
    localparam int GEOM_W          = 64;
    localparam int QUEUE_DEPTH     = 2;
    localparam int S_TDATA_W       = 120;
    localparam int S_TUSER_W       = 1;
    localparam int M_TDATA_W       = 8;
    localparam int M_TUSER_W       = 2;

    typedef enum logic [0:0] {
        REQ_WRITE  = 1'b0,
        REQ_SEARCH = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        GO_LEFT  = 2'd0,
        GO_RIGHT = 2'd1,
        GO_UP    = 2'd2,
        GO_DOWN  = 2'd3
    } dir_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_FOCUS,
        ST_ORIGIN,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // One classified request as it waits between the front and the back.
    typedef struct packed {
        logic                       is_search;
        logic [SLOT_FIELD_W-1:0]    slot;
        logic                       slot_ok;
        logic [COORD_W-1:0]         pos_x;
        logic [COORD_W-1:0]         pos_y;
        logic [COORD_W-1:0]         width;
        logic [COORD_W-1:0]         height;
        logic                       win_valid;
        dir_t                       direction;
        logic                       focus_ok;
        logic [SLOT_FIELD_W-1:0]    focus_slot;
        logic signed [ORIGIN_W-1:0] origin_x2;
        logic signed [ORIGIN_W-1:0] origin_y2;
    } cmd_t;

    // Doubled center along one axis: 2 * edge + extent.
    function automatic logic signed [CENTER_W-1:0] center2(
        input logic [COORD_W-1:0] edge_pos,
        input logic [COORD_W-1:0] extent
    );
        logic [CENTER_W-1:0] sum;
        begin
            sum = {{2{edge_pos[COORD_W-1]}}, edge_pos, 1'b0} + {3'b000, extent};
            return signed'(sum);
        end
    endfunction

    // Returns {wide, narrow} cone membership of the vector (dx, dy).
    function automatic logic [1:0] cone_test(
        input logic signed [DELTA_W-1:0] dx,
        input logic signed [DELTA_W-1:0] dy,
        input dir_t                      dir
    );
        logic                      zero;
        logic signed [DELTA_W-1:0] ax;
        logic signed [DELTA_W-1:0] ay;
        logic                      narrow;
        logic                      wide;
        begin
            zero = (dx == '0) && (dy == '0);
            ax   = dx[DELTA_W-1] ? -dx : dx;
            ay   = dy[DELTA_W-1] ? -dy : dy;
            case (dir)
                GO_LEFT:
                begin
                    narrow = !zero && (-dx >= ay);
                    wide   = !zero && (dx <= 0);
                end
                GO_RIGHT:
                begin
                    narrow = (dx >= ay);
                    wide   = (dx >= 0);
                end
                GO_UP:
                begin
                    narrow = !zero && (-dy >= ax);
                    wide   = (dy <= 0);
                end
                default:
                begin
                    narrow = !zero && (dy >= ax);
                    wide   = (dy >= 0);
                end
            endcase
            return {wide, narrow};
        end
    endfunction

endpackage

/* design/directional_cone_nearest_search_unit.sv */
// Top level of the directional cone nearest-window search unit.
// A write request also returns a result, with found clear.
// A search request scans the table: it reads one table slot per cycle from the geometry RAM
// read port, then a four-stage pipeline drains.
// One request runs at a time; the front queue holds up to two further requests meanwhile.
// Reset clears the valid marks, the queue and the result valid flag, not the geometry RAM.
module directional_cone_nearest_search_unit
    import dcns_pkg::*;
#(
    parameter int MAX_WINDOWS = MAX_WINDOWS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // slot, pos_x, pos_y, width, height, eligible, direction, has_focus, focus_slot,
    // origin_x2, origin_y2, zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // target_slot, zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    // found, used_wide_cone
    output logic [M_TUSER_W-1:0] m_tuser
);

    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    dcns_front #(
        .MAX_WINDOWS(MAX_WINDOWS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    dcns_back #(
        .MAX_WINDOWS(MAX_WINDOWS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

/* design/dcns_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dcns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

/* design/dcns_front.sv */
// Front part: accepts requests, classifies them and queues them for the back part.
module dcns_front
    import dcns_pkg::*;
#(
    parameter int MAX_WINDOWS = MAX_WINDOWS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 q_valid,
    output cmd_t                 q_cmd,
    input  logic                 q_pop
);

    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    cmd_t              q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    cmd_t              cmd_in;
    logic              push;

    always_comb
    begin
        cmd_in.is_search  = (req_t'(s_tuser[0]) == REQ_SEARCH);
        cmd_in.slot       = s_tdata[4:0];
        cmd_in.slot_ok    = (IDX_EXT_W'(s_tdata[4:0]) < IDX_EXT_W'(MAX_WINDOWS));
        cmd_in.pos_x      = s_tdata[20:5];
        cmd_in.pos_y      = s_tdata[36:21];
        cmd_in.width      = s_tdata[52:37];
        cmd_in.height     = s_tdata[68:53];
        cmd_in.win_valid  = s_tdata[69] && (s_tdata[52:37] != '0) && (s_tdata[68:53] != '0);
        cmd_in.direction  = dir_t'(s_tdata[71:70]);
        cmd_in.focus_ok   = s_tdata[72]
                            && (IDX_EXT_W'(s_tdata[77:73]) < IDX_EXT_W'(MAX_WINDOWS));
        cmd_in.focus_slot = s_tdata[77:73];
        cmd_in.origin_x2  = signed'(s_tdata[95:78]);
        cmd_in.origin_y2  = signed'(s_tdata[113:96]);
    end

    assign s_tready = (count_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

/* design/dcns_back.sv */
// Back part: window table, slot scan pipeline with nearest tracking, and result register.
module dcns_back
    import dcns_pkg::*;
#(
    parameter int MAX_WINDOWS = MAX_WINDOWS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  cmd_t                 q_cmd,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser
);

    localparam int SLOT_W = $clog2(MAX_WINDOWS);

    state_t                     state_reg;
    state_t                     state_next;
    cmd_t                       cmd_reg;
    logic [SLOT_W-1:0]          scan_idx_reg;
    logic [SLOT_W-1:0]          scan_idx_next;
    logic [MAX_WINDOWS-1:0]     valid_reg;

    logic                       ram_we;
    logic [SLOT_W-1:0]          ram_waddr;
    logic [GEOM_W-1:0]          ram_wdata;
    logic [SLOT_W-1:0]          ram_raddr;
    logic [GEOM_W-1:0]          ram_rdata;
    logic [IDX_EXT_W-1:0]       slot_ext;
    logic [IDX_EXT_W-1:0]       focus_ext;

    logic signed [CENTER_W-1:0] ox_reg;
    logic signed [CENTER_W-1:0] oy_reg;
    logic signed [CENTER_W-1:0] fcx;
    logic signed [CENTER_W-1:0] fcy;

    // Scan pipeline: read, delta, cone and squares, best update.
    logic                       scan_rd;
    logic                       rd_vld_reg;
    logic [SLOT_W-1:0]          rd_idx_reg;
    logic                       s1_vld_reg;
    logic [SLOT_W-1:0]          s1_idx_reg;
    logic                       s1_elig_reg;
    logic signed [DELTA_W-1:0]  s1_dx_reg;
    logic signed [DELTA_W-1:0]  s1_dy_reg;
    logic                       s2_vld_reg;
    logic [SLOT_W-1:0]          s2_idx_reg;
    logic                       s2_nar_reg;
    logic                       s2_wid_reg;
    logic [SQ_W-1:0]            s2_sqx_reg;
    logic [SQ_W-1:0]            s2_sqy_reg;

    logic signed [CENTER_W-1:0] scx;
    logic signed [CENTER_W-1:0] scy;
    logic                       s1_elig;
    logic [1:0]                 cone;
    logic signed [2*DELTA_W-1:0] prod_x;
    logic signed [2*DELTA_W-1:0] prod_y;
    logic [DIST_W-1:0]          sq_dist;

    logic                       nb_found_reg;
    logic [SLOT_W-1:0]          nb_slot_reg;
    logic [DIST_W-1:0]          nb_dist_reg;
    logic                       wb_found_reg;
    logic [SLOT_W-1:0]          wb_slot_reg;
    logic [DIST_W-1:0]          wb_dist_reg;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       out_load;
    logic                       out_found_reg;
    logic [SLOT_FIELD_W-1:0]    out_slot_reg;
    logic                       out_wide_reg;
    logic [SLOT_W-1:0]          res_idx;
    logic [IDX_EXT_W-1:0]       res_ext;

    assign slot_ext  = IDX_EXT_W'(cmd_reg.slot);
    assign focus_ext = IDX_EXT_W'(cmd_reg.focus_slot);

    assign ram_we    = (state_reg == ST_WRITE) && cmd_reg.slot_ok;
    assign ram_waddr = slot_ext[SLOT_W-1:0];
    assign ram_wdata = {cmd_reg.height, cmd_reg.width, cmd_reg.pos_y, cmd_reg.pos_x};
    assign ram_raddr = (state_reg == ST_SCAN) ? scan_idx_reg : focus_ext[SLOT_W-1:0];
    assign scan_rd   = (state_reg == ST_SCAN);

    dcns_ram #(
        .WIDTH(GEOM_W),
        .DEPTH(MAX_WINDOWS)
    ) u_geom_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Geometry word: x, y, width, height from the lowest bits up.
    assign scx = center2(ram_rdata[15:0], ram_rdata[47:32]);
    assign scy = center2(ram_rdata[31:16], ram_rdata[63:48]);
    assign fcx = scx;
    assign fcy = scy;

    assign s1_elig = valid_reg[rd_idx_reg]
                     && !(cmd_reg.focus_ok && (IDX_EXT_W'(rd_idx_reg) == focus_ext));

    assign cone    = cone_test(s1_dx_reg, s1_dy_reg, cmd_reg.direction);
    assign prod_x  = s1_dx_reg * s1_dx_reg;
    assign prod_y  = s1_dy_reg * s1_dy_reg;
    assign sq_dist = DIST_W'(s2_sqx_reg) + DIST_W'(s2_sqy_reg);

    // The narrow cone wins whenever it found anything.
    assign res_idx  = nb_found_reg ? nb_slot_reg : wb_slot_reg;
    assign res_ext  = IDX_EXT_W'(res_idx);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        q_pop          = 1'b0;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = q_cmd.is_search ? ST_FOCUS : ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_DONE;
            end
            ST_FOCUS:
            begin
                state_next = ST_ORIGIN;
            end
            ST_ORIGIN:
            begin
                scan_idx_next = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == SLOT_W'(MAX_WINDOWS - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !s1_vld_reg && !s2_vld_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_idx_reg  <= '0;
            valid_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            nb_found_reg  <= 1'b0;
            wb_found_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            rd_vld_reg    <= scan_rd;
            s1_vld_reg    <= rd_vld_reg;
            s2_vld_reg    <= s1_vld_reg;
            out_valid_reg <= out_valid_next;
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= cmd_reg.win_valid;
            end
            if (state_reg == ST_ORIGIN)
            begin
                nb_found_reg <= 1'b0;
                wb_found_reg <= 1'b0;
            end
            else if (s2_vld_reg)
            begin
                if (s2_nar_reg && (!nb_found_reg || sq_dist < nb_dist_reg))
                begin
                    nb_found_reg <= 1'b1;
                end
                if (s2_wid_reg && (!wb_found_reg || sq_dist < wb_dist_reg))
                begin
                    wb_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid)
        begin
            cmd_reg <= q_cmd;
        end
        if (state_reg == ST_ORIGIN)
        begin
            // A focused window without area falls back to the given origin.
            if (cmd_reg.focus_ok && ram_rdata[47:32] != '0 && ram_rdata[63:48] != '0)
            begin
                ox_reg <= fcx;
                oy_reg <= fcy;
            end
            else
            begin
                ox_reg <= CENTER_W'(cmd_reg.origin_x2);
                oy_reg <= CENTER_W'(cmd_reg.origin_y2);
            end
        end
        rd_idx_reg  <= scan_idx_reg;
        s1_idx_reg  <= rd_idx_reg;
        s1_elig_reg <= s1_elig;
        s1_dx_reg   <= DELTA_W'(scx) - DELTA_W'(ox_reg);
        s1_dy_reg   <= DELTA_W'(scy) - DELTA_W'(oy_reg);
        s2_idx_reg  <= s1_idx_reg;
        s2_nar_reg  <= s1_elig_reg && cone[0];
        s2_wid_reg  <= s1_elig_reg && cone[1];
        s2_sqx_reg  <= prod_x[SQ_W-1:0];
        s2_sqy_reg  <= prod_y[SQ_W-1:0];
        if (s2_vld_reg && state_reg != ST_ORIGIN)
        begin
            if (s2_nar_reg && (!nb_found_reg || sq_dist < nb_dist_reg))
            begin
                nb_slot_reg <= s2_idx_reg;
                nb_dist_reg <= sq_dist;
            end
            if (s2_wid_reg && (!wb_found_reg || sq_dist < wb_dist_reg))
            begin
                wb_slot_reg <= s2_idx_reg;
                wb_dist_reg <= sq_dist;
            end
        end
        if (out_load)
        begin
            if (cmd_reg.is_search && (nb_found_reg || wb_found_reg))
            begin
                out_found_reg <= 1'b1;
                out_slot_reg  <= res_ext[SLOT_FIELD_W-1:0];
                out_wide_reg  <= !nb_found_reg;
            end
            else
            begin
                out_found_reg <= 1'b0;
                out_slot_reg  <= '0;
                out_wide_reg  <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_slot_reg);
    assign m_tuser  = {out_wide_reg, out_found_reg};

endmodule

/* verif/tb_directional_cone_nearest_search_unit.sv */
// Self-checking testbench for the directional cone nearest-window search unit.
module tb_directional_cone_nearest_search_unit
    import dcns_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS   = MAX_WINDOWS_DEF;
    localparam int RANDOM_REQS = 1730;
    localparam int DRAIN_WAIT  = 3 * NUM_SLOTS;

    typedef struct {
        req_t                       kind;
        logic [SLOT_FIELD_W-1:0]    slot;
        logic [COORD_W-1:0]         pos_x;
        logic [COORD_W-1:0]         pos_y;
        logic [COORD_W-1:0]         width;
        logic [COORD_W-1:0]         height;
        logic                       eligible;
        dir_t                       direction;
        logic                       has_focus;
        logic [SLOT_FIELD_W-1:0]    focus_slot;
        logic [ORIGIN_W-1:0]        origin_x2;
        logic [ORIGIN_W-1:0]        origin_y2;
    } request_t;

    typedef struct {
        logic                    found;
        logic [SLOT_FIELD_W-1:0] target_slot;
        logic                    wide;
    } target_t;

    typedef struct {
        request_t req;
        logic     fixed;
        target_t  want;
    } directed_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // Shadow copy of the window table.
    logic [COORD_W-1:0] win_x [NUM_SLOTS];
    logic [COORD_W-1:0] win_y [NUM_SLOTS];
    logic [COORD_W-1:0] win_w [NUM_SLOTS];
    logic [COORD_W-1:0] win_h [NUM_SLOTS];
    logic               win_ok [NUM_SLOTS];
    logic               win_written [NUM_SLOTS];

    target_t       pending_targets[$];
    directed_row_t directed_rows[$];
    int            error_count;
    int            rx_stall;
    int            rx_cycle;

    directional_cone_nearest_search_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic request_t mk_write(int s, int x, int y, int w, int h, bit elig);
        request_t r;
        begin
            r = '{kind: REQ_WRITE, direction: GO_LEFT, default: '0};
            r.kind     = REQ_WRITE;
            r.slot     = SLOT_FIELD_W'(s);
            r.pos_x    = COORD_W'(x);
            r.pos_y    = COORD_W'(y);
            r.width    = COORD_W'(w);
            r.height   = COORD_W'(h);
            r.eligible = elig;
            r.direction = GO_LEFT;
            return r;
        end
    endfunction

    function automatic request_t mk_search(dir_t d, bit hf, int fs, int ox, int oy);
        request_t r;
        begin
            r = '{kind: REQ_SEARCH, direction: d, default: '0};
            r.kind       = REQ_SEARCH;
            r.direction  = d;
            r.has_focus  = hf;
            r.focus_slot = SLOT_FIELD_W'(fs);
            r.origin_x2  = ORIGIN_W'(ox);
            r.origin_y2  = ORIGIN_W'(oy);
            return r;
        end
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_request(request_t r);
        return {6'b0, r.origin_y2, r.origin_x2, r.focus_slot, r.has_focus, r.direction,
                r.eligible, r.height, r.width, r.pos_y, r.pos_x, r.slot};
    endfunction

    function automatic longint doubled_center(logic [COORD_W-1:0] edge_pos,
                                              logic [COORD_W-1:0] extent);
        return 2 * longint'($signed(edge_pos)) + longint'(extent);
    endfunction

    function automatic bit in_cone(longint dx, longint dy, dir_t d, bit wide);
        longint ax;
        longint ay;
        bit     zero;
        begin
            ax   = dx < 0 ? -dx : dx;
            ay   = dy < 0 ? -dy : dy;
            zero = (dx == 0) && (dy == 0);
            case (d)
                GO_LEFT:  return !zero && (wide ? (dx <= 0) : (-dx >= ay));
                GO_RIGHT: return wide ? (dx >= 0) : (dx >= ay);
                GO_UP:    return wide ? (dy <= 0) : (!zero && (-dy >= ax));
                default:  return wide ? (dy >= 0) : (!zero && (dy >= ax));
            endcase
        end
    endfunction

    // Applies a write to the shadow table, or works out the nearest window for a search.
    function automatic target_t nearest_window_lookup(request_t r);
        target_t res;
        longint  ox;
        longint  oy;
        longint  dx;
        longint  dy;
        longint  dist2;
        longint  best_dist;
        int      best;
        bit      focus;
        begin
            res = '{found: 1'b0, target_slot: '0, wide: 1'b0};
            if (r.kind == REQ_WRITE)
            begin
                win_x[r.slot]       = r.pos_x;
                win_y[r.slot]       = r.pos_y;
                win_w[r.slot]       = r.width;
                win_h[r.slot]       = r.height;
                win_ok[r.slot]      = r.eligible && (r.width != 0) && (r.height != 0);
                win_written[r.slot] = 1'b1;
                return res;
            end
            focus = r.has_focus;
            ox    = longint'($signed(r.origin_x2));
            oy    = longint'($signed(r.origin_y2));
            if (focus && win_w[r.focus_slot] != 0 && win_h[r.focus_slot] != 0)
            begin
                ox = doubled_center(win_x[r.focus_slot], win_w[r.focus_slot]);
                oy = doubled_center(win_y[r.focus_slot], win_h[r.focus_slot]);
            end
            // The narrow cone is tried first; the wide cone only when it finds nothing.
            for (int pass = 0; pass < 2; pass++)
            begin
                best      = -1;
                best_dist = 0;
                for (int s = 0; s < NUM_SLOTS; s++)
                begin
                    if (!win_ok[s] || (focus && s == r.focus_slot))
                        continue;
                    dx = doubled_center(win_x[s], win_w[s]) - ox;
                    dy = doubled_center(win_y[s], win_h[s]) - oy;
                    if (!in_cone(dx, dy, r.direction, pass == 1))
                        continue;
                    dist2 = dx * dx + dy * dy;
                    if (best < 0 || dist2 < best_dist)
                    begin
                        best      = s;
                        best_dist = dist2;
                    end
                end
                if (best >= 0)
                begin
                    res.found       = 1'b1;
                    res.target_slot = SLOT_FIELD_W'(best);
                    res.wide        = (pass == 1);
                    return res;
                end
            end
            return res;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        begin
            r = $urandom_range(99);
            if (r < 70)
                return 0;
            if (r < 93)
                return $urandom_range(3, 1);
            return $urandom_range(60, 15);
        end
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        if ($urandom_range(99) < 85)
            return COORD_W'(int'($urandom_range(300)) - 150);
        return COORD_W'($urandom);
    endfunction

    function automatic logic [COORD_W-1:0] pick_extent();
        int r;
        begin
            r = $urandom_range(99);
            if (r < 10)
                return '0;
            if (r < 20)
                return COORD_W'($urandom);
            return COORD_W'($urandom_range(40, 1));
        end
    endfunction

    // Random request with every field filled, so that unused fields toggle too.
    function automatic request_t random_request();
        request_t r;
        int       pick;
        int       src;
        begin
            r.kind       = ($urandom_range(99) < 45) ? REQ_WRITE : REQ_SEARCH;
            r.slot       = SLOT_FIELD_W'($urandom);
            r.pos_x      = pick_coord();
            r.pos_y      = pick_coord();
            r.width      = pick_extent();
            r.height     = pick_extent();
            r.eligible   = ($urandom_range(99) < 85);
            r.direction  = dir_t'($urandom_range(3));
            r.has_focus  = ($urandom_range(99) < 60);
            r.focus_slot = SLOT_FIELD_W'($urandom);
            src = $urandom_range(99);
            if (src < 70)
            begin
                r.origin_x2 = ORIGIN_W'(int'($urandom_range(600)) - 300);
                r.origin_y2 = ORIGIN_W'(int'($urandom_range(600)) - 300);
            end
            else if (src < 85)
            begin
                r.origin_x2 = ORIGIN_W'($urandom);
                r.origin_y2 = ORIGIN_W'($urandom);
            end
            else
            begin
                // Sit the origin on a window center to hit the zero vector.
                pick = $urandom_range(NUM_SLOTS - 1);
                r.origin_x2 = ORIGIN_W'(doubled_center(win_x[pick], win_w[pick]));
                r.origin_y2 = ORIGIN_W'(doubled_center(win_y[pick], win_h[pick]));
            end
            // A focused slot must have been written before its geometry is used.
            if (r.kind == REQ_SEARCH && r.has_focus && !win_written[r.focus_slot])
                r.has_focus = 1'b0;
            return r;
        end
    endfunction

    task automatic add_row(request_t r, bit fixed, bit f, int t, bit w);
        directed_row_t row;
        begin
            row.req   = r;
            row.fixed = fixed;
            row.want  = '{found: f, target_slot: SLOT_FIELD_W'(t), wide: w};
            directed_rows.push_back(row);
        end
    endtask

    task automatic build_directed();
        begin
            // Empty table: nothing can be found.
            add_row(mk_search(GO_RIGHT, 1'b0, 0, 0, 0), 1'b1, 1'b0, 0, 1'b0);
            add_row(mk_search(GO_LEFT, 1'b0, 31, -131072, 131071), 1'b1, 1'b0, 0, 1'b0);
            add_row(mk_write(0, -32768, -32768, 65535, 65535, 1'b1), 1'b1, 1'b0, 0, 1'b0);
            add_row(mk_write(31, 32767, 32767, 1, 1, 1'b1), 1'b1, 1'b0, 0, 1'b0);
            // Empty rectangles and an ineligible window.
            add_row(mk_write(1, 0, 0, 0, 10, 1'b1), 1'b1, 1'b0, 0, 1'b0);
            add_row(mk_write(2, 0, 0, 10, 0, 1'b1), 1'b1, 1'b0, 0, 1'b0);
            add_row(mk_write(3, 100, 100, 10, 10, 1'b0), 1'b1, 1'b0, 0, 1'b0);
            add_row(mk_write(4, 10, 10, 4, 4, 1'b1), 1'b1, 1'b0, 0, 1'b0);
            add_row(mk_write(5, 30, 10, 4, 4, 1'b1), 1'b1, 1'b0, 0, 1'b0);
            add_row(mk_write(6, 10, -20, 4, 4, 1'b1), 1'b1, 1'b0, 0, 1'b0);
            // On the diagonal from slot 4: exactly on the cone boundary.
            add_row(mk_write(7, 40, 40, 4, 4, 1'b1), 1'b1, 1'b0, 0, 1'b0);
            // Same geometry as slot 5, so the tie goes to the lower slot.
            add_row(mk_write(8, 30, 10, 4, 4, 1'b1), 1'b1, 1'b0, 0, 1'b0);
            add_row(mk_search(GO_RIGHT, 1'b1, 4, 0, 0), 1'b0, 1'b0, 0, 1'b0);
            add_row(mk_search(GO_DOWN, 1'b1, 4, 0, 0), 1'b0, 1'b0, 0, 1'b0);
            add_row(mk_search(GO_UP, 1'b1, 4, 0, 0), 1'b0, 1'b0, 0, 1'b0);
            add_row(mk_search(GO_LEFT, 1'b1, 4, 0, 0), 1'b0, 1'b0, 0, 1'b0);
            // Origin on the center of slot 4: zero vector.
            add_row(mk_search(GO_RIGHT, 1'b0, 4, 24, 24), 1'b0, 1'b0, 0, 1'b0);
            add_row(mk_search(GO_LEFT, 1'b0, 4, 24, 24), 1'b0, 1'b0, 0, 1'b0);
            // Focused slots 1 and 2 have no area and fall back to the given origin; slot 3 has area and is used.
            add_row(mk_search(GO_UP, 1'b1, 1, 24, 24), 1'b0, 1'b0, 0, 1'b0);
            add_row(mk_search(GO_RIGHT, 1'b1, 2, 64, 24), 1'b0, 1'b0, 0, 1'b0);
            add_row(mk_search(GO_DOWN, 1'b1, 3, 0, 0), 1'b0, 1'b0, 0, 1'b0);
            add_row(mk_search(GO_RIGHT, 1'b0, 0, -131072, -131072), 1'b0, 1'b0, 0, 1'b0);
            add_row(mk_search(GO_LEFT, 1'b0, 0, 131071, 131071), 1'b0, 1'b0, 0, 1'b0);
            add_row(mk_write(4, 10, 10, 4, 4, 1'b0), 1'b1, 1'b0, 0, 1'b0);
            add_row(mk_search(GO_UP, 1'b0, 0, 24, 24), 1'b0, 1'b0, 0, 1'b0);
        end
    endtask

    // Drives one request and records its expected result once it is accepted.
    task automatic send_request(request_t r, bit fixed, target_t want, int gap);
        target_t predicted;
        begin
            @(negedge clk);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= pack_request(r);
            s_tuser  <= r.kind;
            do
                @(posedge clk);
            while (!s_tready);
            predicted = nearest_window_lookup(r);
            pending_targets.push_back(fixed ? want : predicted);
        end
    endtask

    // Receiver side: random stalls, with stretches where it never stalls.
    always @(negedge clk)
    begin
        rx_cycle = rx_cycle + 1;
        if (rx_stall > 0)
        begin
            m_tready <= 1'b0;
            rx_stall = rx_stall - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (((rx_cycle / 3000) % 4) != 3 && $urandom_range(99) < 12)
                rx_stall = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        target_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_targets.size() == 0)
            begin
                $error("result with no request waiting: tdata %h tuser %b", m_tdata, m_tuser);
                error_count = error_count + 1;
            end
            else
            begin
                want = pending_targets.pop_front();
                if (m_tuser[0] !== want.found)
                begin
                    $error("found: expected %0d, actual %0d", want.found, m_tuser[0]);
                    error_count = error_count + 1;
                end
                if (m_tdata[SLOT_FIELD_W-1:0] !== want.target_slot)
                begin
                    $error("target_slot: expected %0d, actual %0d", want.target_slot,
                           m_tdata[SLOT_FIELD_W-1:0]);
                    error_count = error_count + 1;
                end
                if (m_tuser[1] !== want.wide)
                begin
                    $error("used_wide_cone: expected %0d, actual %0d", want.wide, m_tuser[1]);
                    error_count = error_count + 1;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        target_t  none;
        request_t r;
        int       gap;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        error_count = 0;
        rx_stall    = 0;
        rx_cycle    = 0;
        none        = '{found: 1'b0, target_slot: '0, wide: 1'b0};
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            win_x[s]       = '0;
            win_y[s]       = '0;
            win_w[s]       = '0;
            win_h[s]       = '0;
            win_ok[s]      = 1'b0;
            win_written[s] = 1'b0;
        end
        build_directed();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].want,
                         pick_gap());

        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            r   = random_request();
            gap = (((i / 150) % 3) == 2) ? 0 : pick_gap();
            send_request(r, 1'b0, none, gap);
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (pending_targets.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0 && pending_targets.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
